FILE: design/cls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types and constants for the compacting list with search.
// ----------------------------------------------------------------------------
package cls_pkg;

  // Value written into a slot freed by a remove
  localparam logic [31:0] MARKER = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;   // append the key at the first free cell
    logic rem;   // cells at or above the index take their upper neighbor
    logic cmp;   // load match flags from a compare against the key
    logic scan;  // move match flags one cell toward cell 0
  } cls_ctrl_t;

endpackage

FILE: design/cls_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_cell
// One list slot: holds an entry, its occupied flag and a match flag, and
// exchanges them with its neighbors on insert, remove, compare and scan.
// ----------------------------------------------------------------------------
module cls_cell
  import cls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cls_ctrl_t   ctrl_i,
  input  logic [31:0] key_i,
  input  logic        prev_occ_i,
  input  logic        at_or_above_i,
  input  logic [31:0] nxt_entry_i,
  input  logic        nxt_occ_i,
  input  logic        nxt_match_i,
  output logic [31:0] entry_o,
  output logic        occ_o,
  output logic        match_o
);

  logic [31:0] entry_q, entry_d;
  logic        occ_q, occ_d;
  logic        match_q, match_d;
  logic        take_key, take_nxt;

  // Decide what this slot loads this cycle
  always_comb begin
    take_key = ctrl_i.ins && !occ_q && prev_occ_i;
    take_nxt = ctrl_i.rem && occ_q && at_or_above_i;

    entry_d = entry_q;
    occ_d   = occ_q;
    if (take_key) begin
      entry_d = key_i;
      occ_d   = 1'b1;
    end else if (take_nxt) begin
      entry_d = nxt_occ_i ? nxt_entry_i : MARKER;
      occ_d   = nxt_occ_i;
    end

    match_d = match_q;
    if (ctrl_i.cmp) begin
      match_d = occ_q && (entry_q == key_i);
    end else if (ctrl_i.scan) begin
      match_d = nxt_match_i;
    end
  end

  // Hold control flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      match_q <= match_d;
    end
  end

  // Entry payload: only meaningful while occupied
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign occ_o   = occ_q;
  assign match_o = match_q;

endmodule

FILE: design/compacting_list_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_list_with_search
// Fixed-capacity list of signed 32-bit values with append, compacting
// remove and lowest-index search, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each beat on the input carries an operation; exactly one result beat comes
// back per input beat, in order. Insert, remove, rejected requests and the
// unused operation code finish at the accepting edge: every cell acts in
// parallel and the result lands in the output register at that edge. In a
// search all cells compare at the accepting edge, then the match flags step
// down the cell row one slot per cycle until the head cell sees a match or
// the scan passes the last occupied slot. A search of an empty list finishes
// at the accepting edge. A new beat is taken once the previous one has
// finished and its result is gone or leaving.
// ----------------------------------------------------------------------------
module compacting_list_with_search
  import cls_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [3:0]         found_index_o,
  output logic [4:0]         occupancy_o,
  output logic               is_full_o,
  output logic               is_empty_o
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > 4) ? CW : 4;
  localparam int SW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [SW-1:0]   scan_cnt_q, scan_cnt_d;
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [3:0]      found_q, found_d;
  logic [CW-1:0]   occ_res_q, occ_res_d;

  cls_ctrl_t       ctrl;
  logic            in_fire;
  logic            is_full, is_empty;
  logic [CMP_W-1:0] idx_ext, count_ext;
  logic            rem_ok;
  logic            scan_hit, scan_last;

  logic [31:0]         entry [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] at_or_above;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_full   = (count_q == CW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign idx_ext   = CMP_W'(index_i);
  assign count_ext = CMP_W'(count_q);
  assign rem_ok    = !is_empty && (idx_ext < count_ext);

  assign scan_hit  = match[0];
  assign scan_last = (CW'(scan_cnt_q) == count_q - CW'(1));

  // Drive the cell row command
  always_comb begin
    ctrl.ins  = in_fire && (op_e'(operation_i) == OP_INSERT) && !is_full;
    ctrl.rem  = in_fire && (op_e'(operation_i) == OP_REMOVE) && rem_ok;
    ctrl.cmp  = in_fire && (op_e'(operation_i) == OP_SEARCH);
    ctrl.scan = (state_q == S_SCAN) && !scan_hit && !scan_last;
  end

  // Sequence requests and fill the output register
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_cnt_d  = scan_cnt_q;
    status_d    = status_q;
    found_d     = found_q;
    occ_res_d   = occ_res_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          found_d     = '0;
          status_d    = ST_OK;
          out_valid_d = 1'b1;
          case (op_e'(operation_i))
            OP_INSERT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else if (!rem_ok) begin
                status_d = ST_RANGE;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            OP_SEARCH: begin
              if (is_empty) begin
                status_d = ST_NOTFOUND;
              end else begin
                out_valid_d = 1'b0;
                scan_cnt_d  = '0;
                state_d     = S_SCAN;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
          occ_res_d = count_d;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          status_d    = scan_hit ? ST_OK : ST_NOTFOUND;
          found_d     = scan_hit ? 4'(scan_cnt_q) : 4'd0;
          occ_res_d   = count_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          scan_cnt_d = scan_cnt_q + SW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    found_q   <= found_d;
    occ_res_q <= occ_res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign occupancy_o   = 5'(occ_res_q);
  assign is_full_o     = (occ_res_q == CW'(CAPACITY));
  assign is_empty_o    = (occ_res_q == '0);

  // Row of slot cells, cell 0 at the head of the list
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic        prev_occ;
    logic [31:0] nxt_entry;
    logic        nxt_occ;
    logic        nxt_match;

    assign at_or_above[i] = (CMP_W'(i) >= idx_ext);

    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign nxt_entry = MARKER;
      assign nxt_occ   = 1'b0;
      assign nxt_match = 1'b0;
    end else begin : g_link
      assign nxt_entry = entry[i+1];
      assign nxt_occ   = occ[i+1];
      assign nxt_match = match[i+1];
    end

    cls_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (value_i),
      .prev_occ_i    (prev_occ),
      .at_or_above_i (at_or_above[i]),
      .nxt_entry_i   (nxt_entry),
      .nxt_occ_i     (nxt_occ),
      .nxt_match_i   (nxt_match),
      .entry_o       (entry[i]),
      .occ_o         (occ[i]),
      .match_o       (match[i])
    );
  end

`ifndef NO_ASSERTIONS
  // Occupied cells always agree with the count
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ) == 32'(count_q))
    else $error("occupied cells disagree with count");

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("count above capacity");

  // A successful remove shrinks the list by one
  a_rem_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> count_q == $past(count_q) - CW'(1))
    else $error("remove did not shrink the list");

  // No result is shown, and the list is not empty, while a search is scanning
  a_scan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !out_valid_q && count_q != '0)
    else $error("result visible or empty list during scan");
`endif

endmodule

FILE: dv/tb_compacting_list_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compacting_list_with_search
// Self-checking bench for the compacting list: a scoreboard list mirrors the
// entries and the count, predicts every result beat, and a monitor compares
// each beat field by field. Directed corner tests come first, then biased
// random traffic with random gaps on the request side and random stalls on
// the result side, one long result stall and two full drains of the sender.
// ----------------------------------------------------------------------------
module tb_compacting_list_with_search;
  import cls_pkg::*;

  localparam int          CAPACITY   = 16;
  localparam int          IDLE_LIMIT = 3000;
  localparam logic [31:0] INT_MIN    = 32'h8000_0000;

  // Scoreboard result beat
  typedef struct packed {
    status_e    status;
    logic [3:0] found_index;
    logic [4:0] occupancy;
    logic       is_full;
    logic       is_empty;
  } list_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = OP_INSERT;
  logic signed [31:0] value_i = '0;
  logic [3:0]         index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [3:0]         found_index_o;
  logic [4:0]         occupancy_o;
  logic               is_full_o;
  logic               is_empty_o;

  // Mirror of the list contents and the pending results
  logic [31:0]  list_entries [CAPACITY];
  int           list_count;
  list_result_t pending_results [$];
  list_result_t oldest_pending;

  int error_count = 0;
  int idle_cycles = 0;
  int result_hold_request = 0;
  bit sender_gaps = 1'b1;

  compacting_list_with_search #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .occupancy_o  (occupancy_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o)
  );

  // Generate a 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the mirror list and return the result it yields
  function automatic list_result_t apply_request(op_e op, logic [31:0] value,
                                                 logic [3:0] index);
    list_result_t res;
    bit           hit;
    res        = '0;
    res.status = ST_OK;
    hit        = 1'b0;
    case (op)
      OP_INSERT: begin
        if (list_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_entries[list_count] = value;
          list_count++;
        end
      end
      OP_REMOVE: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(index) >= list_count) begin
          res.status = ST_RANGE;
        end else begin
          // Close the gap and refill the freed top slot
          for (int i = int'(index); i + 1 < list_count; i++)
            list_entries[i] = list_entries[i + 1];
          list_entries[list_count - 1] = MARKER;
          list_count--;
        end
      end
      OP_SEARCH: begin
        res.status = ST_NOTFOUND;
        for (int i = 0; i < list_count; i++) begin
          if (!hit && list_entries[i] == value) begin
            hit             = 1'b1;
            res.status      = ST_OK;
            res.found_index = 4'(i);
          end
        end
      end
      default: ;
    endcase
    res.occupancy = 5'(list_count);
    res.is_full   = (list_count == CAPACITY);
    res.is_empty  = (list_count == 0);
    return res;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Corner values, a small pool that repeats often, or any 32-bit pattern
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      case ($urandom_range(0, 4))
        0:       return INT_MIN;
        1:       return MARKER;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'd1;
        default: return 32'd0;
      endcase
    end
    if (roll < 50) return 32'($signed($urandom_range(0, 7)) - 3);
    return $urandom;
  endfunction

  // Send one request beat and record its expected result
  task automatic send_request(input op_e op, input logic [31:0] value,
                              input logic [3:0] index);
    int gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= value;
    index_i     <= index;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_request(op, value, index));
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the request side until every pending result has come back
  task automatic wait_until_drained();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_list();
    send_request(OP_REMOVE, 32'd0, 4'd0);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 4'd15);
    send_request(OP_SEARCH, MARKER, 4'd0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
    wait_until_drained();
  endtask

  task automatic test_fill_to_capacity();
    logic [31:0] fill_values [CAPACITY];
    fill_values = '{INT_MIN, MARKER, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h5555_5555,
                    32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'h0F0F_0F0F,
                    32'hF0F0_F0F0, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFE};
    foreach (fill_values[i]) send_request(OP_INSERT, fill_values[i], 4'd0);
    // Overflow, duplicate lookup, and a miss on a full list
    send_request(OP_INSERT, 32'd9, 4'd0);
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 4'd0);
    send_request(OP_SEARCH, 32'hFFFF_FFFE, 4'd0);
    send_request(OP_SEARCH, 32'd12345, 4'd0);
    wait_until_drained();
  endtask

  task automatic test_remove_compaction();
    send_request(OP_REMOVE, 32'd0, 4'd15);
    send_request(OP_REMOVE, 32'd0, 4'd15);
    send_request(OP_REMOVE, 32'd0, 4'd0);
    send_request(OP_SEARCH, MARKER, 4'd0);
    send_request(OP_UNUSED, 32'd0, 4'd0);
    wait_until_drained();
  endtask

  // Random traffic with weighted insert and remove shares
  task automatic run_random_phase(input int beats, input int insert_pct,
                                  input int remove_pct);
    int          roll;
    op_e         op;
    logic [31:0] value;
    logic [3:0]  index;
    for (int n = 0; n < beats; n++) begin
      if (n % 64 == 0) sender_gaps = ($urandom_range(0, 3) != 0);
      roll  = $urandom_range(0, 99);
      value = pick_value();
      index = 4'($urandom_range(0, 15));
      if (roll < insert_pct) begin
        op = OP_INSERT;
      end else if (roll < insert_pct + remove_pct) begin
        op = OP_REMOVE;
        if (list_count > 0 && $urandom_range(0, 3) != 0)
          index = 4'($urandom_range(0, list_count - 1));
      end else if (roll < 97) begin
        op = OP_SEARCH;
        if (list_count > 0 && $urandom_range(0, 99) < 60)
          value = list_entries[$urandom_range(0, list_count - 1)];
      end else begin
        op = OP_UNUSED;
      end
      send_request(op, value, index);
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_random_phase(450, 40, 30);
    run_random_phase(350, 60, 15);
    run_random_phase(350, 15, 60);
    run_random_phase(300, 55, 10);
    run_random_phase(300, 35, 35);
    wait_until_drained();
  endtask

  // Stall the result side for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    result_hold_request = 300;
    for (int n = 0; n < 24; n++) begin
      if (n % 3 == 0) send_request(OP_INSERT, pick_value(), 4'd0);
      else if (n % 3 == 1) send_request(OP_SEARCH, pick_value(), 4'd0);
      else send_request(OP_REMOVE, 32'd0, 4'($urandom_range(0, 15)));
    end
    wait_until_drained();
  endtask

  // Pause the sender mid-stream until the list has answered everything
  task automatic test_sender_pause();
    run_random_phase(15, 45, 25);
    wait_until_drained();
    run_random_phase(15, 25, 45);
    wait_until_drained();
  endtask

  // Stimulus sequence
  initial begin
    for (int i = 0; i < CAPACITY; i++) list_entries[i] = MARKER;
    list_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_to_capacity();
    test_remove_compaction();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    wait_until_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Drive result-side ready: random stalls, calm stretches, requested hold-off
  initial begin : result_ready
    int stall_left;
    int ready_run;
    stall_left = 0;
    ready_run  = 0;
    forever begin
      @(posedge clk_i);
      if (result_hold_request > 0) begin
        stall_left          = result_hold_request;
        result_hold_request = 0;
        ready_run           = 0;
      end
      if (stall_left == 0 && ready_run == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: stall_left = pick_gap();
          3:       ready_run = $urandom_range(20, 80);
          default: ready_run = 1;
        endcase
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (ready_run > 0) ready_run--;
      end
    end
  end

  // Compare each result beat with the oldest pending prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending: status %0d", status_o);
        error_count++;
      end else begin
        oldest_pending = pending_results.pop_front();
        if (status_o !== oldest_pending.status) begin
          $error("status: expected %0d, actual %0d", oldest_pending.status, status_o);
          error_count++;
        end
        if (found_index_o !== oldest_pending.found_index) begin
          $error("found_index: expected %0d, actual %0d",
                 oldest_pending.found_index, found_index_o);
          error_count++;
        end
        if (occupancy_o !== oldest_pending.occupancy) begin
          $error("occupancy: expected %0d, actual %0d",
                 oldest_pending.occupancy, occupancy_o);
          error_count++;
        end
        if (is_full_o !== oldest_pending.is_full) begin
          $error("is_full: expected %0d, actual %0d", oldest_pending.is_full, is_full_o);
          error_count++;
        end
        if (is_empty_o !== oldest_pending.is_empty) begin
          $error("is_empty: expected %0d, actual %0d",
                 oldest_pending.is_empty, is_empty_o);
          error_count++;
        end
      end
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
